/* src/drqr_pkg.sv */
package drqr_pkg;

  // phase of the incoming datagram
  typedef enum logic [1:0] {
    PH_HEADER,
    PH_NAME,
    PH_TAIL,
    PH_DISCARD
  } phase_e;

  // work handed from the front to the back
  typedef enum logic [1:0] {
    CMD_HDR,   // send the rewritten 12-byte header
    CMD_BYTE,  // send one question byte
    CMD_ANS    // send one question byte, then the answer record
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic        abort;  // follow with an abort item
    logic [7:0]  data;
  } cmd_t;

  typedef logic [11:0][7:0] hdr_t;

  localparam int unsigned HdrBytes = 12;

  // configuration register indexes
  localparam logic CfgAnswerAddress = 1'b0;
  localparam logic CfgAnswerTtl     = 1'b1;

  localparam logic [31:0] AnswerAddressRst = 32'hC0A8_0401;
  localparam logic [31:0] AnswerTtlRst     = 32'd60;

  // rewritten header bytes
  localparam logic [7:0] HdrFlagsHi = 8'h84;
  localparam logic [7:0] HdrFlagsLo = 8'h00;
  localparam logic [7:0] AnCountHi  = 8'h00;
  localparam logic [7:0] AnCountLo  = 8'h01;

  // fixed answer record bytes
  localparam logic [7:0] AnsPtrHi   = 8'hC0;
  localparam logic [7:0] AnsPtrLo   = 8'h0C;
  localparam logic [7:0] AnsTypeHi  = 8'h00;
  localparam logic [7:0] AnsTypeLo  = 8'h01;
  localparam logic [7:0] AnsClassHi = 8'h00;
  localparam logic [7:0] AnsClassLo = 8'h01;
  localparam logic [7:0] AnsLenHi   = 8'h00;
  localparam logic [7:0] AnsLenLo   = 8'h04;

endpackage

/* src/drqr_front.sv */
module drqr_front #(
  parameter int MaxDatagram = 512
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      in_byte_i,
  input  logic            in_last_i,
  output logic            push_o,
  output drqr_pkg::cmd_t  cmd_o,
  input  logic            full_i,
  input  logic            hdr_release_i,
  output drqr_pkg::hdr_t  hdr_o
);

  localparam int CntW = $clog2(MaxDatagram + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxDatagram);

  drqr_pkg::phase_e phase_q, phase_d;
  logic [CntW-1:0]  cnt_q, cnt_d, cnt_sat;
  logic [7:0]       skip_q, skip_d;
  logic [2:0]       tail_q, tail_d, tail_inc;
  logic             hdr_pend_q, hdr_pend_d;
  drqr_pkg::hdr_t   hdr_q;
  logic             accept, cut, hdr_we;
  logic [3:0]       hdr_idx;

  // header bytes may not be overwritten until the back has sent them
  assign in_ready_o = !full_i && !(phase_q == drqr_pkg::PH_HEADER && hdr_pend_q);
  assign accept     = in_valid_i && in_ready_o;
  assign cnt_sat    = (cnt_q < MaxCnt) ? cnt_q + CntW'(1) : cnt_q;
  assign cut        = in_last_i || (cnt_sat == MaxCnt);
  assign tail_inc   = tail_q + 3'd1;
  assign hdr_idx    = cnt_sat[3:0] - 4'd1;
  assign hdr_we     = accept && phase_q == drqr_pkg::PH_HEADER
                      && cnt_sat <= CntW'(drqr_pkg::HdrBytes);
  assign hdr_o      = hdr_q;

  // classify each byte and decide what the back has to send
  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    skip_d     = skip_q;
    tail_d     = tail_q;
    hdr_pend_d = hdr_pend_q && !hdr_release_i;
    push_o     = 1'b0;
    cmd_o      = '{kind: drqr_pkg::CMD_BYTE, abort: cut, data: in_byte_i};
    if (accept) begin
      cnt_d = cnt_sat;
      case (phase_q)
        drqr_pkg::PH_HEADER: begin
          if (cnt_sat == CntW'(drqr_pkg::HdrBytes)) begin
            if (hdr_q[4] == 8'd0 && hdr_q[5] == 8'd0) begin
              phase_d = drqr_pkg::PH_DISCARD;
            end else begin
              push_o     = 1'b1;
              cmd_o.kind = drqr_pkg::CMD_HDR;
              hdr_pend_d = 1'b1;
              skip_d     = 8'd0;
              tail_d     = 3'd0;
              phase_d    = cut ? drqr_pkg::PH_DISCARD : drqr_pkg::PH_NAME;
            end
          end else if (cnt_sat > CntW'(drqr_pkg::HdrBytes)) begin
            phase_d = drqr_pkg::PH_DISCARD;
          end
        end
        drqr_pkg::PH_NAME: begin
          push_o = 1'b1;
          if (skip_q != 8'd0) begin
            skip_d = skip_q - 8'd1;
          end else if (in_byte_i == 8'd0) begin
            phase_d = drqr_pkg::PH_TAIL;
            tail_d  = 3'd0;
          end else begin
            skip_d = in_byte_i;
          end
          if (cut) begin
            phase_d = drqr_pkg::PH_DISCARD;
          end
        end
        drqr_pkg::PH_TAIL: begin
          push_o = 1'b1;
          tail_d = tail_inc;
          if (tail_inc >= 3'd4) begin
            cmd_o.kind  = drqr_pkg::CMD_ANS;
            cmd_o.abort = 1'b0;
            phase_d     = drqr_pkg::PH_DISCARD;
          end else if (cut) begin
            phase_d = drqr_pkg::PH_DISCARD;
          end
        end
        default: begin
          phase_d = drqr_pkg::PH_DISCARD;
        end
      endcase
      // end of datagram restarts header collection
      if (in_last_i) begin
        phase_d = drqr_pkg::PH_HEADER;
        cnt_d   = '0;
        skip_d  = 8'd0;
        tail_d  = 3'd0;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= drqr_pkg::PH_HEADER;
      cnt_q      <= '0;
      skip_q     <= 8'd0;
      tail_q     <= 3'd0;
      hdr_pend_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      skip_q     <= skip_d;
      tail_q     <= tail_d;
      hdr_pend_q <= hdr_pend_d;
    end
  end

  // header store
  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hdr_q[hdr_idx] <= in_byte_i;
    end
  end

endmodule

/* src/drqr_cmd_fifo.sv */
module drqr_cmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  drqr_pkg::cmd_t  data_i,
  output logic            full_o,
  output logic            valid_o,
  input  logic            pop_i,
  output drqr_pkg::cmd_t  data_o
);

  drqr_pkg::cmd_t mem_q [2];
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  // entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

/* src/drqr_back.sv */
module drqr_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  drqr_pkg::cmd_t  cmd_i,
  output logic            pop_o,
  output logic            hdr_release_o,
  input  drqr_pkg::hdr_t  hdr_i,
  input  logic [31:0]     answer_address_i,
  input  logic [31:0]     answer_ttl_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o,
  output logic            out_abort_o
);

  logic [4:0] step_q, step_d;
  logic       oval_q, oval_d;
  logic [7:0] obyte_q, obyte_d;
  logic       olast_q, olast_d, oabort_q, oabort_d;
  logic       advance, done;
  logic [7:0] it_byte, hdr_byte, ans_byte;
  logic       it_last, it_abort;

  assign advance       = !oval_q || out_ready_i;
  assign pop_o         = advance && cmd_valid_i && done;
  assign hdr_release_o = pop_o && cmd_i.kind == drqr_pkg::CMD_HDR;

  // header byte with flags and answer count rewritten
  always_comb begin
    case (step_q[3:0])
      4'd2:    hdr_byte = drqr_pkg::HdrFlagsHi;
      4'd3:    hdr_byte = drqr_pkg::HdrFlagsLo;
      4'd6:    hdr_byte = drqr_pkg::AnCountHi;
      4'd7:    hdr_byte = drqr_pkg::AnCountLo;
      4'd12, 4'd13, 4'd14, 4'd15: hdr_byte = 8'd0;
      default: hdr_byte = hdr_i[step_q[3:0]];
    endcase
  end

  // answer record byte, steps 1 to 16
  always_comb begin
    case (step_q)
      5'd1:    ans_byte = drqr_pkg::AnsPtrHi;
      5'd2:    ans_byte = drqr_pkg::AnsPtrLo;
      5'd3:    ans_byte = drqr_pkg::AnsTypeHi;
      5'd4:    ans_byte = drqr_pkg::AnsTypeLo;
      5'd5:    ans_byte = drqr_pkg::AnsClassHi;
      5'd6:    ans_byte = drqr_pkg::AnsClassLo;
      5'd7:    ans_byte = answer_ttl_i[31:24];
      5'd8:    ans_byte = answer_ttl_i[23:16];
      5'd9:    ans_byte = answer_ttl_i[15:8];
      5'd10:   ans_byte = answer_ttl_i[7:0];
      5'd11:   ans_byte = drqr_pkg::AnsLenHi;
      5'd12:   ans_byte = drqr_pkg::AnsLenLo;
      5'd13:   ans_byte = answer_address_i[31:24];
      5'd14:   ans_byte = answer_address_i[23:16];
      5'd15:   ans_byte = answer_address_i[15:8];
      5'd16:   ans_byte = answer_address_i[7:0];
      default: ans_byte = 8'd0;
    endcase
  end

  // item for the current step of the head command
  always_comb begin
    it_byte  = cmd_i.data;
    it_last  = 1'b0;
    it_abort = 1'b0;
    done     = 1'b0;
    case (cmd_i.kind)
      drqr_pkg::CMD_HDR: begin
        if (step_q == 5'd12) begin
          it_byte  = 8'd0;
          it_last  = 1'b1;
          it_abort = 1'b1;
          done     = 1'b1;
        end else begin
          it_byte = hdr_byte;
          done    = !cmd_i.abort && step_q == 5'd11;
        end
      end
      drqr_pkg::CMD_BYTE: begin
        if (step_q == 5'd0) begin
          done = !cmd_i.abort;
        end else begin
          it_byte  = 8'd0;
          it_last  = 1'b1;
          it_abort = 1'b1;
          done     = 1'b1;
        end
      end
      drqr_pkg::CMD_ANS: begin
        if (step_q != 5'd0) begin
          it_byte = ans_byte;
          it_last = step_q == 5'd16;
          done    = step_q == 5'd16;
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  // output register and step counter
  always_comb begin
    step_d   = step_q;
    oval_d   = oval_q;
    obyte_d  = obyte_q;
    olast_d  = olast_q;
    oabort_d = oabort_q;
    if (advance) begin
      oval_d   = cmd_valid_i;
      obyte_d  = it_byte;
      olast_d  = it_last;
      oabort_d = it_abort;
      if (cmd_valid_i) begin
        step_d = done ? 5'd0 : step_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 5'd0;
      oval_q <= 1'b0;
    end else begin
      step_q <= step_d;
      oval_q <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obyte_q  <= obyte_d;
    olast_q  <= olast_d;
    oabort_q <= oabort_d;
  end

  assign out_valid_o = oval_q;
  assign out_byte_o  = obyte_q;
  assign out_last_o  = olast_q;
  assign out_abort_o = oabort_q;

endmodule

/* src/dns_query_answer_rewriter_core.sv */
// channel   | dir | tdata          | tlast    | tuser
// s_axis    | in  | [7:0] in_byte  | in_last  | -
// m_axis    | out | [7:0] out_byte | out_last | [0] out_abort
// cfg       | in  | cfg_wdata_i: index 0 answer_address, index 1 answer_ttl
//
// unstalled, question bytes pass at one byte per cycle; a header emits 12 bytes and
// the closing question byte 17, one per cycle from the single output register
// the front keeps taking bytes through a 2-entry command queue while the back
// drains; the next datagram's header bytes wait until the previous header is sent
// reset is asynchronous, active low; the header store is not cleared
// a stall on m_axis holds the output register and backs up into the queue
module dns_query_answer_rewriter_core #(
  parameter int MaxDatagram = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,   // [0] out_abort
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [31:0] cfg_wdata_i
);

  logic [31:0]    addr_q, ttl_q;
  logic           push, full, cmd_valid, pop, hdr_release;
  drqr_pkg::cmd_t cmd_in, cmd_head;
  drqr_pkg::hdr_t hdr;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= drqr_pkg::AnswerAddressRst;
      ttl_q  <= drqr_pkg::AnswerTtlRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        drqr_pkg::CfgAnswerAddress: addr_q <= cfg_wdata_i;
        drqr_pkg::CfgAnswerTtl:     ttl_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  drqr_front #(
    .MaxDatagram(MaxDatagram)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .push_o       (push),
    .cmd_o        (cmd_in),
    .full_i       (full),
    .hdr_release_i(hdr_release),
    .hdr_o        (hdr)
  );

  drqr_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (cmd_in),
    .full_o (full),
    .valid_o(cmd_valid),
    .pop_i  (pop),
    .data_o (cmd_head)
  );

  drqr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd_head),
    .pop_o           (pop),
    .hdr_release_o   (hdr_release),
    .hdr_i           (hdr),
    .answer_address_i(addr_q),
    .answer_ttl_i    (ttl_q),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_byte_o      (m_axis_tdata),
    .out_last_o      (m_axis_tlast),
    .out_abort_o     (m_axis_tuser)
  );

endmodule

/* test/dns_query_answer_rewriter_core_tb.sv */
module dns_query_answer_rewriter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxDg        = 512;
  localparam int RandPerPhase = 45;   // query bytes per configuration phase
  localparam int DrainWait    = 20;   // settle time once no reply byte is pending
  localparam int WatchLimit   = 1000; // cycles without any transfer

  // one reply byte as seen on m_axis
  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       abort;
  } reply_t;

  // one query byte as driven on s_axis
  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } qbyte_t;

  typedef enum logic [3:0] {
    DG_SHORT,
    DG_HDR_CUT,
    DG_ZERO_QD,
    DG_FULL,
    DG_NAME_CUT,
    DG_TAIL_CUT,
    DG_NOISE,
    DG_LONG,
    DG_OVERSIZE
  } dg_kind_e;

  // how the final reply byte of a directed datagram is checked
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_ABORT,
    CHK_ANSWER_END
  } chk_e;

  typedef struct packed {
    dg_kind_e   kind;
    logic [7:0] fill;
    chk_e       chk;
  } dir_row_t;

  // directed datagrams, reset configuration
  localparam dir_row_t DirTab [7] = '{
    '{DG_SHORT,    8'h00, CHK_MODEL},      // short datagram, no reply
    '{DG_HDR_CUT,  8'hFF, CHK_ABORT},      // ends right at the header
    '{DG_ZERO_QD,  8'hFF, CHK_MODEL},      // zero question count, no reply
    '{DG_FULL,     8'h00, CHK_ANSWER_END}, // complete query
    '{DG_NAME_CUT, 8'hFF, CHK_ABORT},      // cut inside the name
    '{DG_TAIL_CUT, 8'h00, CHK_ABORT},      // cut inside type/class
    '{DG_FULL,     8'hFF, CHK_ANSWER_END}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] in_byte
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [7:0] out_byte
  logic        m_axis_tlast;
  logic        m_axis_tuser;   // [0] out_abort
  logic        cfg_we_i;
  logic        cfg_addr_i;
  logic [31:0] cfg_wdata_i;

  dns_query_answer_rewriter_core #(
    .MaxDatagram(MaxDg)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // shadow of the responder state
  drqr_pkg::phase_e q_phase;
  logic [9:0]       q_count;
  logic [7:0]       q_skip;
  logic [2:0]       q_tail;
  drqr_pkg::hdr_t   q_hdr;
  logic [31:0]      ans_addr;
  logic [31:0]      ans_ttl;

  reply_t reply_q[$];   // reply bytes still to come
  qbyte_t dg_q[$];      // datagram being sent
  int     fed;          // query bytes sent
  int     fails;
  int     idle_cycles;
  logic   tx_idle;
  logic   rx_idle;

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // reply byte bookkeeping
  task automatic add_reply(input logic [7:0] b, input logic last, input logic abort);
    reply_q.push_back('{b: b, last: last, abort: abort});
  endtask

  task automatic add_abort();
    add_reply(8'h00, 1'b1, 1'b1);
    q_phase = drqr_pkg::PH_DISCARD;
  endtask

  // forged reply bytes caused by one query byte
  task automatic forge_reply(input logic [7:0] b, input logic l);
    logic       cut;
    logic [7:0] v;
    logic [7:0] rec [16];
    if (q_count < MaxDg) q_count = q_count + 10'd1;
    cut = l || (q_count >= MaxDg);
    case (q_phase)
      drqr_pkg::PH_HEADER: begin
        if (q_count >= 1 && q_count <= drqr_pkg::HdrBytes) q_hdr[q_count[3:0] - 4'd1] = b;
        if (q_count == drqr_pkg::HdrBytes) begin
          if (q_hdr[4] == 8'h00 && q_hdr[5] == 8'h00) begin
            q_phase = drqr_pkg::PH_DISCARD;
          end else begin
            for (int i = 0; i < drqr_pkg::HdrBytes; i++) begin
              case (i)
                2:       v = drqr_pkg::HdrFlagsHi;
                3:       v = drqr_pkg::HdrFlagsLo;
                6:       v = drqr_pkg::AnCountHi;
                7:       v = drqr_pkg::AnCountLo;
                default: v = q_hdr[i];
              endcase
              add_reply(v, 1'b0, 1'b0);
            end
            q_phase = drqr_pkg::PH_NAME;
            q_skip  = '0;
            q_tail  = '0;
            if (cut) add_abort();
          end
        end else if (q_count > drqr_pkg::HdrBytes) begin
          q_phase = drqr_pkg::PH_DISCARD;
        end
      end
      drqr_pkg::PH_NAME: begin
        add_reply(b, 1'b0, 1'b0);
        // any nonzero byte at a label boundary counts as a length
        if (q_skip != 0) begin
          q_skip = q_skip - 8'd1;
        end else if (b == 8'h00) begin
          q_phase = drqr_pkg::PH_TAIL;
          q_tail  = '0;
        end else begin
          q_skip = b;
        end
        if (cut) add_abort();
      end
      drqr_pkg::PH_TAIL: begin
        add_reply(b, 1'b0, 1'b0);
        q_tail = q_tail + 3'd1;
        if (q_tail >= 3'd4) begin
          rec = '{drqr_pkg::AnsPtrHi, drqr_pkg::AnsPtrLo,
                  drqr_pkg::AnsTypeHi, drqr_pkg::AnsTypeLo,
                  drqr_pkg::AnsClassHi, drqr_pkg::AnsClassLo,
                  ans_ttl[31:24], ans_ttl[23:16], ans_ttl[15:8], ans_ttl[7:0],
                  drqr_pkg::AnsLenHi, drqr_pkg::AnsLenLo,
                  ans_addr[31:24], ans_addr[23:16], ans_addr[15:8], ans_addr[7:0]};
          for (int i = 0; i < 16; i++) add_reply(rec[i], i == 15, 1'b0);
          q_phase = drqr_pkg::PH_DISCARD;
        end else if (cut) begin
          add_abort();
        end
      end
      default: q_phase = drqr_pkg::PH_DISCARD;
    endcase
    if (l) begin
      q_phase = drqr_pkg::PH_HEADER;
      q_count = '0;
      q_skip  = '0;
      q_tail  = '0;
    end
  endtask

  function automatic logic [7:0] pick(input logic use_fill, input logic [7:0] fill);
    return use_fill ? fill : 8'($urandom_range(0, 255));
  endfunction

  // build one query datagram into dg_q
  task automatic make_dgram(input dg_kind_e kind, input logic use_fill,
                            input logic [7:0] fill);
    int         n;
    int         len;
    int         cut;
    int         term_at;
    logic [7:0] v;
    dg_q.delete();
    if (kind == DG_SHORT || kind == DG_NOISE) begin
      n = (kind == DG_NOISE) ? $urandom_range(1, 30) :
          use_fill ? 2 : $urandom_range(1, drqr_pkg::HdrBytes - 1);
      for (int i = 0; i < n; i++) dg_q.push_back('{b: pick(use_fill, fill), last: 1'b0});
    end else begin
      // header, question count forced as the kind needs
      for (int i = 0; i < drqr_pkg::HdrBytes; i++) begin
        v = pick(use_fill, fill);
        if (kind == DG_ZERO_QD && (i == 4 || i == 5)) v = 8'h00;
        else if (i == 5 && dg_q[4].b == 8'h00 && v == 8'h00) v = 8'h01;
        dg_q.push_back('{b: v, last: 1'b0});
      end
      if (kind == DG_ZERO_QD) begin
        n = use_fill ? 0 : $urandom_range(0, 6);
        for (int i = 0; i < n; i++) dg_q.push_back('{b: pick(1'b0, 8'h00), last: 1'b0});
      end else begin
        // name labels
        n = (kind == DG_OVERSIZE) ? 2 : use_fill ? 1 : $urandom_range(0, 3);
        for (int j = 0; j < n; j++) begin
          if (kind == DG_OVERSIZE) len = 255;
          else if (use_fill) len = 1;
          else if (kind == DG_LONG && j == 0) len = $urandom_range(64, 255);
          else len = $urandom_range(1, 8);
          dg_q.push_back('{b: 8'(len), last: 1'b0});
          for (int i = 0; i < len; i++) dg_q.push_back('{b: pick(use_fill, fill), last: 1'b0});
        end
        term_at = dg_q.size();
        dg_q.push_back('{b: 8'h00, last: 1'b0});
        // type and class
        for (int i = 0; i < 4; i++) dg_q.push_back('{b: pick(use_fill, fill), last: 1'b0});
        n = use_fill ? 0 : $urandom_range(0, 3);
        for (int i = 0; i < n; i++) dg_q.push_back('{b: pick(1'b0, 8'h00), last: 1'b0});
        // truncation point
        case (kind)
          DG_HDR_CUT:  cut = drqr_pkg::HdrBytes - 1;
          DG_NAME_CUT: cut = use_fill ? drqr_pkg::HdrBytes :
                             $urandom_range(drqr_pkg::HdrBytes, term_at);
          DG_TAIL_CUT: cut = use_fill ? term_at + 2 : $urandom_range(term_at + 1, term_at + 3);
          default:     cut = dg_q.size() - 1;
        endcase
        while (dg_q.size() > cut + 1) void'(dg_q.pop_back());
      end
    end
    dg_q[dg_q.size() - 1].last = 1'b1;
  endtask

  // one s_axis transfer; called at a rising edge
  task automatic send_byte(input qbyte_t q);
    int gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= q.b;
    s_axis_tlast  <= q.last;
    do @(posedge clk_i); while (!s_axis_tready);
    fed++;
    forge_reply(q.b, q.last);
  endtask

  task automatic send_dgram(input chk_e chk);
    tx_idle = ($urandom_range(0, 3) != 0);
    foreach (dg_q[i]) send_byte(dg_q[i]);
    // typed-in final byte for the directed rows
    case (chk)
      CHK_ABORT:      reply_q[$] = '{b: 8'h00, last: 1'b1, abort: 1'b1};
      CHK_ANSWER_END: reply_q[$] = '{b: drqr_pkg::AnswerAddressRst[7:0], last: 1'b1,
                                     abort: 1'b0};
      default: ;
    endcase
  endtask

  // hold the sender until every reply byte has arrived
  task automatic drain_replies();
    s_axis_tvalid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == drqr_pkg::CfgAnswerAddress) ans_addr = val;
    else ans_ttl = val;
    @(posedge clk_i);
  endtask

  // stimulus
  initial begin : stim
    dg_kind_e kind;
    int       r;
    int       target;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = drqr_pkg::CfgAnswerAddress;
    cfg_wdata_i   = '0;
    q_phase       = drqr_pkg::PH_HEADER;
    q_count       = '0;
    q_skip        = '0;
    q_tail        = '0;
    q_hdr         = '0;
    ans_addr      = drqr_pkg::AnswerAddressRst;
    ans_ttl       = drqr_pkg::AnswerTtlRst;
    fed           = 0;
    tx_idle       = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed datagrams
    foreach (DirTab[i]) begin
      make_dgram(DirTab[i].kind, 1'b1, DirTab[i].fill);
      send_dgram(DirTab[i].chk);
    end

    // random datagrams, one configuration per phase
    for (int ph = 0; ph < 5; ph++) begin
      if (ph != 0) begin
        drain_replies();
        case (ph)
          1: begin
            set_reg(drqr_pkg::CfgAnswerAddress, 32'h0000_0000);
            set_reg(drqr_pkg::CfgAnswerTtl, 32'h0000_0000);
          end
          2: begin
            set_reg(drqr_pkg::CfgAnswerAddress, 32'hFFFF_FFFF);
            set_reg(drqr_pkg::CfgAnswerTtl, 32'hFFFF_FFFF);
          end
          default: begin
            set_reg(drqr_pkg::CfgAnswerAddress, $urandom);
            set_reg(drqr_pkg::CfgAnswerTtl, $urandom);
          end
        endcase
      end
      target = fed + RandPerPhase;
      while (fed < target) begin
        r = $urandom_range(0, 99);
        if (r < 55) kind = DG_FULL;
        else if (r < 67) kind = DG_NAME_CUT;
        else if (r < 75) kind = DG_TAIL_CUT;
        else if (r < 80) kind = DG_HDR_CUT;
        else if (r < 86) kind = DG_ZERO_QD;
        else if (r < 92) kind = DG_SHORT;
        else if (r < 97) kind = DG_NOISE;
        else kind = DG_LONG;
        make_dgram(kind, 1'b0, 8'h00);
        send_dgram(CHK_MODEL);
        if ($urandom_range(0, 9) == 0) drain_replies();
      end
    end

    // oversize datagram, then a normal one to see the block recover
    make_dgram(DG_OVERSIZE, 1'b0, 8'h00);
    send_dgram(CHK_MODEL);
    make_dgram(DG_FULL, 1'b0, 8'h00);
    send_dgram(CHK_MODEL);

    s_axis_tvalid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (fails == 0 && reply_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // receiver with random stalls, checks every reply transfer
  initial begin : rx_side
    int     gap;
    reply_t want;
    reply_t got;
    m_axis_tready = 1'b0;
    fails         = 0;
    rx_idle       = 1'b1;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 31) == 0) rx_idle = !rx_idle;
      gap = rx_idle ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got = '{b: m_axis_tdata, last: m_axis_tlast, abort: m_axis_tuser};
      if (reply_q.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected reply transfer: byte %h last %b abort %b",
                   got.b, got.last, got.abort);
      end else begin
        want = reply_q.pop_front();
        if (got !== want) begin
          fails++;
          if (fails <= 10)
            $display("mismatch: expected byte %h last %b abort %b, got byte %h last %b abort %b",
                     want.b, want.last, want.abort, got.b, got.last, got.abort);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  initial idle_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WatchLimit) begin
          $display("status: fail");
          $finish;
        end
      end
    end
  end

endmodule

/* sim.f */
src/drqr_pkg.sv
src/drqr_front.sv
src/drqr_cmd_fifo.sv
src/drqr_back.sv
src/dns_query_answer_rewriter_core.sv
test/dns_query_answer_rewriter_core_tb.sv
